>>> src/iba_pkg.sv
`timescale 1ns / 1ps

package iba_pkg;

	// Table size and link encoding; the null link is one past the last entry
	localparam int MAX_PEERS = 64;
	localparam int IDX_W     = $clog2(MAX_PEERS);
	localparam int LINK_W    = IDX_W + 1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [LINK_W-1:0] count_t;

	localparam link_t LINK_NULL = link_t'(MAX_PEERS);

	// Operation codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STAT_GRANTED  = 2'd0,
		STAT_NO_IDLE  = 2'd1,
		STAT_RELEASED = 2'd2,
		STAT_IGNORED  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic op;
		idx_t peer_id;
	} req_item_t;

	typedef struct packed {
		status_t status;
		idx_t    granted_index;
		count_t  idle_count;
		logic    oldest_busy_valid;
		idx_t    oldest_busy;
	} rsp_item_t;

	// Write requests to the link store, one port per memory; the busy flag
	// is stored with the prev link
	typedef struct packed {
		logic  next_we;
		idx_t  next_addr;
		link_t next_data;
		logic  prev_we;
		idx_t  prev_addr;
		link_t prev_data;
		logic  busy_data;
	} link_wr_t;

	// Read data of one entry, defaults already applied
	typedef struct packed {
		link_t next_link;
		link_t prev_link;
		logic  busy;
	} link_rd_t;

endpackage

>>> src/iba_links.sv
`timescale 1ns / 1ps

module iba_links (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              rd_en,
	input  iba_pkg::idx_t     rd_addr,
	input  iba_pkg::link_wr_t wr,
	output iba_pkg::link_rd_t rd
);
	import iba_pkg::*;

	// Next links, and prev links with the busy flag on top, one entry per peer
	link_t           next_mem [MAX_PEERS];
	logic [LINK_W:0] prev_mem [MAX_PEERS];

	// Written marks; an unwritten entry reads as its post-init value
	logic [MAX_PEERS-1:0] next_vld_q;
	logic [MAX_PEERS-1:0] prev_vld_q;

	link_t           next_rd_s1;
	logic [LINK_W:0] prev_rd_s1;
	logic            next_vld_s1;
	logic            prev_vld_s1;
	idx_t            addr_s1;

	// Memory arrays: one write per memory, one registered read
	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
		if (wr.prev_we) begin
			prev_mem[wr.prev_addr] <= {wr.busy_data, wr.prev_data};
		end
		if (rd_en) begin
			next_rd_s1 <= next_mem[rd_addr];
			prev_rd_s1 <= prev_mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	// Written marks, cleared by reset and by a peer count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vld_q  <= '0;
			prev_vld_q  <= '0;
			next_vld_s1 <= 1'b0;
			prev_vld_s1 <= 1'b0;
		end else begin
			if (clear) begin
				next_vld_q <= '0;
				prev_vld_q <= '0;
			end else begin
				if (wr.next_we) begin
					next_vld_q[wr.next_addr] <= 1'b1;
				end
				if (wr.prev_we) begin
					prev_vld_q[wr.prev_addr] <= 1'b1;
				end
			end
			if (rd_en) begin
				next_vld_s1 <= next_vld_q[rd_addr];
				prev_vld_s1 <= prev_vld_q[rd_addr];
			end
		end
	end

	// Unwritten: next is i+1, busy is clear. Prev is only read for busy
	// entries, which always had it written on acquire.
	assign rd.next_link = next_vld_s1 ? next_rd_s1 : (link_t'(addr_s1) + link_t'(1));
	assign rd.prev_link = prev_rd_s1[LINK_W-1:0];
	assign rd.busy      = prev_vld_s1 & prev_rd_s1[LINK_W];

endmodule

>>> src/iba_ctrl.sv
`timescale 1ns / 1ps

module iba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  iba_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output iba_pkg::rsp_item_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  iba_pkg::count_t    cfg_data,
	output logic               clear,
	output logic               rd_en,
	output iba_pkg::idx_t      rd_addr,
	output iba_pkg::link_wr_t  wr,
	input  iba_pkg::link_rd_t  rd
);
	import iba_pkg::*;

	state_t    state_q, state_d;
	logic      op_s1;
	idx_t      e_s1;
	count_t    n_active_q, n_active_d;
	link_t     idle_head_q, idle_head_d;
	link_t     idle_tail_q, idle_tail_d;
	link_t     busy_head_q, busy_head_d;
	link_t     busy_tail_q, busy_tail_d;
	count_t    idle_total_q, idle_total_d;
	rsp_item_t rsp_q, rsp_d;
	logic      rsp_valid_q;

	logic      accept;
	logic      cfg_take;
	logic      exec_go;
	link_t     e_link;
	link_t     prv;
	link_t     nxt;
	count_t    n_clamped;

	// Peer count written as 0 means 1, above the table size means the table size
	always_comb begin
		if (cfg_data == '0) begin
			n_clamped = count_t'(1);
		end else if (cfg_data > count_t'(MAX_PEERS)) begin
			n_clamped = count_t'(MAX_PEERS);
		end else begin
			n_clamped = cfg_data;
		end
	end

	// Handshakes and link store read
	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;
	assign cfg_take  = cfg_valid & cfg_ready;
	assign clear     = cfg_take;
	assign rd_en     = accept;
	assign rd_addr   = (req.op == OP_RELEASE) ? req.peer_id : idle_head_q[IDX_W-1:0];
	assign exec_go   = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign e_link    = link_t'(e_s1);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state, list updates, link writes and the result
	always_comb begin
		state_d      = state_q;
		n_active_d   = n_active_q;
		idle_head_d  = idle_head_q;
		idle_tail_d  = idle_tail_q;
		busy_head_d  = busy_head_q;
		busy_tail_d  = busy_tail_q;
		idle_total_d = idle_total_q;
		wr           = '0;
		prv          = LINK_NULL;
		nxt          = LINK_NULL;
		rsp_d        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cfg_take) begin
					n_active_d   = n_clamped;
					idle_head_d  = '0;
					idle_tail_d  = n_clamped - count_t'(1);
					busy_head_d  = LINK_NULL;
					busy_tail_d  = LINK_NULL;
					idle_total_d = n_clamped;
				end
				if (accept) begin
					state_d = S_EXEC;
					if (req.op == OP_RELEASE) begin
						// A release always leaves the named peer not busy;
						// a refused one was not busy to begin with
						wr.prev_we   = 1'b1;
						wr.prev_addr = req.peer_id;
						wr.prev_data = LINK_NULL;
						wr.busy_data = 1'b0;
						// Tail's next is never read, so linking the released
						// peer behind the idle tail is safe even if refused
						if (idle_total_q != '0) begin
							wr.next_we   = 1'b1;
							wr.next_addr = idle_tail_q[IDX_W-1:0];
							wr.next_data = link_t'(req.peer_id);
						end
					end
				end
			end
			S_EXEC: begin
				if (exec_go) begin
					state_d = S_IDLE;
					if (op_s1 == OP_ACQUIRE) begin
						if (idle_total_q == '0) begin
							rsp_d.status = STAT_NO_IDLE;
						end else begin
							// Pop idle head
							nxt = (e_link == idle_tail_q) ? LINK_NULL : rd.next_link;
							idle_head_d = nxt;
							if (nxt == LINK_NULL) begin
								idle_tail_d = LINK_NULL;
							end
							// Append to busy tail
							if (busy_head_q == LINK_NULL) begin
								busy_head_d = e_link;
							end else begin
								wr.next_we   = 1'b1;
								wr.next_addr = busy_tail_q[IDX_W-1:0];
								wr.next_data = e_link;
							end
							wr.prev_we   = 1'b1;
							wr.prev_addr = e_s1;
							wr.prev_data = busy_tail_q;
							wr.busy_data = 1'b1;
							busy_tail_d  = e_link;
							idle_total_d = idle_total_q - count_t'(1);
							rsp_d.status        = STAT_GRANTED;
							rsp_d.granted_index = e_s1;
						end
					end else begin
						if (e_link >= n_active_q || !rd.busy) begin
							rsp_d.status = STAT_IGNORED;
						end else begin
							// Unlink from the busy list
							prv = (e_link == busy_head_q) ? LINK_NULL : rd.prev_link;
							nxt = (e_link == busy_tail_q) ? LINK_NULL : rd.next_link;
							if (prv != LINK_NULL) begin
								wr.next_we   = 1'b1;
								wr.next_addr = prv[IDX_W-1:0];
								wr.next_data = nxt;
							end else begin
								busy_head_d = nxt;
							end
							if (nxt != LINK_NULL) begin
								wr.prev_we   = 1'b1;
								wr.prev_addr = nxt[IDX_W-1:0];
								wr.prev_data = prv;
								wr.busy_data = 1'b1;
							end else begin
								busy_tail_d = prv;
							end
							// Idle tail link and busy flag already written at accept
							if (idle_head_q == LINK_NULL) begin
								idle_head_d = e_link;
							end
							idle_tail_d  = e_link;
							idle_total_d = idle_total_q + count_t'(1);
							rsp_d.status = STAT_RELEASED;
						end
					end
					rsp_d.idle_count        = idle_total_d;
					rsp_d.oldest_busy_valid = (busy_head_d != LINK_NULL);
					rsp_d.oldest_busy       = (busy_head_d != LINK_NULL) ?
						busy_head_d[IDX_W-1:0] : '0;
				end
			end
		endcase
	end

	// Control state and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			n_active_q   <= count_t'(MAX_PEERS);
			idle_head_q  <= '0;
			idle_tail_q  <= link_t'(MAX_PEERS - 1);
			busy_head_q  <= LINK_NULL;
			busy_tail_q  <= LINK_NULL;
			idle_total_q <= count_t'(MAX_PEERS);
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			n_active_q   <= n_active_d;
			idle_head_q  <= idle_head_d;
			idle_tail_q  <= idle_tail_d;
			busy_head_q  <= busy_head_d;
			busy_tail_q  <= busy_tail_d;
			idle_total_q <= idle_total_d;
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item in flight and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.op;
			e_s1  <= rd_addr;
		end
		if (exec_go) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> src/idle_busy_peer_allocator.sv
`timescale 1ns / 1ps

// Channel | handshake             | item
// --------+-----------------------+--------------------------------------------
// req     | req_valid/req_ready   | op, peer_id (acquire or release)
// rsp     | rsp_valid/rsp_ready   | status, granted_index, idle_count, oldest busy
// cfg     | cfg_valid/cfg_ready   | cfg_data: active peer count, reinitialises lists
//
// Each item passes two states: on acceptance in S_IDLE the peer's links are read,
// and in S_EXEC the neighbours are written back and the result register is loaded.
// The result register lets the next item be taken while a result waits;
// a second result stalls in the write-back cycle until rsp_ready.
// Reset and a peer count write need no clearing pass: per-entry written marks
// make untouched entries read as their initial links.

module idle_busy_peer_allocator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  iba_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output iba_pkg::rsp_item_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  iba_pkg::count_t    cfg_data
);
	import iba_pkg::*;

	logic     clear;
	logic     rd_en;
	idx_t     rd_addr;
	link_wr_t wr;
	link_rd_t rd;

	// Sequencer and list heads
	iba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.clear     (clear),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.rd        (rd)
	);

	// Link and busy memories
	iba_links u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

endmodule

>>> src/iba_checker.sv
`timescale 1ns / 1ps

module iba_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input iba_pkg::rsp_item_t rsp
);
	import iba_pkg::*;

	// A waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted during write-back");

	// A grant leaves at least one busy peer
	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_GRANTED |-> rsp.oldest_busy_valid)
		else $error("grant with empty busy list");

	// A refused acquire only happens with no idle peer
	a_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_NO_IDLE |-> rsp.idle_count == '0)
		else $error("acquire refused with idle peers");

	// Idle count never exceeds the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.idle_count <= count_t'(MAX_PEERS))
		else $error("idle count out of range");

endmodule

bind idle_busy_peer_allocator iba_checker u_iba_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import iba_pkg::*;

	localparam int FREE_CHAIN  = 0;
	localparam int USED_CHAIN  = 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int GAP_PCT     = 11;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	count_t    cfg_data  = '0;

	idle_busy_peer_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Shadow of the peer table: two linked lists over the same entries
	link_t  fwd [MAX_PEERS];
	link_t  back [MAX_PEERS];
	bit     held [MAX_PEERS];
	link_t  head_of [2];
	link_t  tail_of [2];
	count_t free_total;
	count_t peer_limit;

	// Items waiting to be offered, and replies owed by the block
	req_item_t req_backlog [$];
	rsp_item_t due_replies [$];
	int        queued_total = 0;
	int        sent_total   = 0;
	int        fault_count  = 0;

	// Handshake between the sequence and the clocked processes
	bit        steady     = 1'b0;
	int        hold_asks  = 0;
	int        hold_done  = 0;
	int        hold_left  = 0;
	int        cfg_asks   = 0;
	int        cfg_done   = 0;
	count_t    cfg_word   = '0;
	int        quiet      = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic count_t clamp_peers(count_t v);
		if (v == 0)
			return count_t'(1);
		if (v > MAX_PEERS)
			return count_t'(MAX_PEERS);
		return v;
	endfunction

	// Peers 0..n-1 idle in order, nothing busy
	function automatic void relist(count_t n);
		for (int i = 0; i < MAX_PEERS; i++) begin
			fwd[i]  = LINK_NULL;
			back[i] = LINK_NULL;
			held[i] = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			fwd[i]  = (i + 1 < n) ? link_t'(i + 1) : LINK_NULL;
			back[i] = (i > 0) ? link_t'(i - 1) : LINK_NULL;
		end
		peer_limit          = n;
		head_of[FREE_CHAIN] = '0;
		tail_of[FREE_CHAIN] = link_t'(n - 1);
		head_of[USED_CHAIN] = LINK_NULL;
		tail_of[USED_CHAIN] = LINK_NULL;
		free_total          = n;
	endfunction

	function automatic void chain_tail(int l, idx_t e);
		fwd[e] = LINK_NULL;
		if (head_of[l] == LINK_NULL) begin
			back[e]    = LINK_NULL;
			head_of[l] = link_t'(e);
		end else begin
			fwd[tail_of[l][IDX_W-1:0]] = link_t'(e);
			back[e] = tail_of[l];
		end
		tail_of[l] = link_t'(e);
	endfunction

	function automatic void unchain(int l, idx_t e);
		link_t p;
		link_t n;
		p = back[e];
		n = fwd[e];
		if (p != LINK_NULL)
			fwd[p[IDX_W-1:0]] = n;
		else
			head_of[l] = n;
		if (n != LINK_NULL)
			back[n[IDX_W-1:0]] = p;
		else
			tail_of[l] = p;
		back[e] = LINK_NULL;
		fwd[e]  = LINK_NULL;
	endfunction

	// One request against the shadow table; returns the reply it must produce
	function automatic rsp_item_t apply_request(req_item_t r);
		rsp_item_t o;
		idx_t      e;
		o = '0;
		if (r.op == OP_ACQUIRE) begin
			if (head_of[FREE_CHAIN] == LINK_NULL) begin
				o.status = STAT_NO_IDLE;
			end else begin
				e = head_of[FREE_CHAIN][IDX_W-1:0];
				unchain(FREE_CHAIN, e);
				chain_tail(USED_CHAIN, e);
				held[e]         = 1'b1;
				free_total      = free_total - count_t'(1);
				o.status        = STAT_GRANTED;
				o.granted_index = e;
			end
		end else if (count_t'(r.peer_id) >= peer_limit || !held[r.peer_id]) begin
			o.status = STAT_IGNORED;
		end else begin
			unchain(USED_CHAIN, r.peer_id);
			chain_tail(FREE_CHAIN, r.peer_id);
			held[r.peer_id] = 1'b0;
			free_total      = free_total + count_t'(1);
			o.status        = STAT_RELEASED;
		end
		o.idle_count = free_total;
		if (head_of[USED_CHAIN] != LINK_NULL) begin
			o.oldest_busy_valid = 1'b1;
			o.oldest_busy       = head_of[USED_CHAIN][IDX_W-1:0];
		end
		return o;
	endfunction

	// Request driver: predicts on acceptance, then offers the next backlog item
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				due_replies.push_back(apply_request(req));
				sent_total++;
			end
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor: checks each item against the oldest owed reply
	always @(posedge clk) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_replies.size() == 0) begin
					if (fault_count < 10)
						$display("%0t unexpected reply st=%0d gi=%0d ic=%0d ov=%0b ob=%0d",
							$realtime, rsp.status, rsp.granted_index, rsp.idle_count,
							rsp.oldest_busy_valid, rsp.oldest_busy);
					fault_count++;
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status ||
					    rsp.granted_index !== want.granted_index ||
					    rsp.idle_count !== want.idle_count ||
					    rsp.oldest_busy_valid !== want.oldest_busy_valid ||
					    rsp.oldest_busy !== want.oldest_busy) begin
						if (fault_count < 10) begin
							$display("%0t reply mismatch: want st=%0d gi=%0d ic=%0d ov=%0b ob=%0d",
								$realtime, want.status, want.granted_index,
								want.idle_count, want.oldest_busy_valid, want.oldest_busy);
							$display("%0t                  got st=%0d gi=%0d ic=%0d ov=%0b ob=%0d",
								$realtime, rsp.status, rsp.granted_index,
								rsp.idle_count, rsp.oldest_busy_valid, rsp.oldest_busy);
						end
						fault_count++;
					end
				end
			end
			// Long hold-off on request, otherwise random back-pressure
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (hold_asks != hold_done) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= steady || ($urandom_range(99) >= GAP_PCT);
			end
		end
	end

	// Peer count writes; the shadow table is rebuilt at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			relist(clamp_peers(cfg_data));
			cfg_done++;
			cfg_valid <= 1'b0;
		end else if (!cfg_valid && cfg_asks != cfg_done) begin
			cfg_data  <= cfg_word;
			cfg_valid <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted item on any channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_req(input logic op, input int peer);
		req_item_t r;
		r.op      = op;
		r.peer_id = idx_t'(peer);
		req_backlog.push_back(r);
		queued_total++;
	endtask

	// Wait until every queued item is accepted and every reply is in
	task automatic settle();
		while (sent_total != queued_total || due_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_peer_count(input count_t v);
		settle();
		repeat (3) @(posedge clk);
		cfg_word = v;
		cfg_asks++;
		while (cfg_done != cfg_asks)
			@(posedge clk);
	endtask

	task automatic random_phase(input count_t setting, input int items, input int acquire_pct,
	                            input bit no_gaps, input bit with_hold);
		count_t    n;
		req_item_t r;
		write_peer_count(setting);
		n      = clamp_peers(setting);
		steady = no_gaps;
		for (int k = 0; k < items; k++) begin
			r.op = ($urandom_range(99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE;
			// mostly peers within the active range, some anywhere in the table
			if ($urandom_range(99) < 80)
				r.peer_id = idx_t'($urandom_range(n - 1));
			else
				r.peer_id = idx_t'($urandom_range(MAX_PEERS - 1));
			req_backlog.push_back(r);
			queued_total++;
		end
		if (with_hold)
			hold_asks++;
		settle();
		steady = 1'b0;
	endtask

	initial begin
		relist(count_t'(MAX_PEERS));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: releases of idle peers, then a short grant and release
		queue_req(OP_RELEASE, 63);
		queue_req(OP_RELEASE, 0);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_ACQUIRE, 63);
		queue_req(OP_RELEASE, 1);
		queue_req(OP_RELEASE, 0);

		// Zero peers taken as one: exhaustion, unknown peer, double release
		write_peer_count(count_t'(0));
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_RELEASE, 1);
		queue_req(OP_RELEASE, 0);
		queue_req(OP_RELEASE, 0);

		// Three peers: unlink from the middle, head and tail of the busy list
		write_peer_count(count_t'(3));
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_RELEASE, 1);
		queue_req(OP_RELEASE, 0);
		queue_req(OP_RELEASE, 2);
		queue_req(OP_ACQUIRE, 0);
		queue_req(OP_RELEASE, 63);

		// Random phases over several peer counts; above the table is clamped
		random_phase(count_t'(127), 250, 65, 1'b1, 1'b0);
		random_phase(count_t'(64), 200, 55, 1'b0, 1'b1);
		random_phase(count_t'(2), 150, 50, 1'b0, 1'b0);
		random_phase(count_t'($urandom_range(8, 1)), 150, 55, 1'b0, 1'b0);
		random_phase(count_t'($urandom_range(127)), 150, 60, 1'b0, 1'b0);
		random_phase(count_t'(100), 100, 70, 1'b0, 1'b0);

		settle();
		repeat (20) @(posedge clk);
		if (fault_count == 0 && due_replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
